FILE: hw/rtl/sprite_scanline_evaluator_assert.svh
// Assertion macros for the checker of this block.
`ifndef SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH
`define SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite evaluator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite evaluator check failed");

`endif

FILE: hw/rtl/sse_pkg.sv
`timescale 1ns / 1ps
package sse_pkg;

  localparam int SPRITE_COUNT_DEF  = 64;
  localparam int MAX_PER_LINE_DEF  = 8;
  localparam int VISIBLE_LINES_DEF = 240;

  // Sprite memory is kept as one 32-bit row per sprite.
  localparam int ROWS  = 64;
  localparam int ROW_W = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [1:0] REG_SPRITES_ENABLED = 2'd0;
  localparam logic [1:0] REG_TALL_SPRITES    = 2'd1;
  localparam logic [1:0] REG_PATTERN_PAGE    = 2'd2;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] attr;
    logic [7:0] tile;
    logic [7:0] y;
  } sse_row_t;

  typedef struct packed {
    logic enabled;
    logic tall;
    logic page;
  } sse_cfg_t;

  typedef struct packed {
    logic        hit;
    logic [12:0] pattern_address;
    logic [7:0]  x;
    logic [1:0]  palette;
    logic        behind;
    logic        hflip;
  } sse_rec_t;

endpackage

FILE: hw/rtl/sse_ram.sv
`timescale 1ns / 1ps
module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sse_record.sv
`timescale 1ns / 1ps
module sse_record (
  input  sse_pkg::sse_row_t row,
  input  logic [8:0]        line,
  input  sse_pkg::sse_cfg_t cfg,
  output sse_pkg::sse_rec_t rec
);
  import sse_pkg::*;

  logic [8:0] diff;
  logic [3:0] row_sel;
  logic [8:0] tile9;

  always_comb begin
    diff    = line - {1'b0, row.y};
    row_sel = diff[3:0];
    if (row.attr[7]) begin
      row_sel = cfg.tall ? (4'd15 - row_sel) : (4'd7 - row_sel);
    end
    // Tall sprites take their bank from tile bit 0 and the lower half from the next tile.
    tile9 = {1'b0, row.tile};
    if (cfg.tall && row.tile[0]) begin
      tile9 = {1'b1, row.tile[7:1], 1'b0};
    end
    if (row_sel[3]) begin
      tile9 = tile9 + 9'd1;
    end
    rec.hit = (line >= {1'b0, row.y}) && (diff[8:4] == 5'd0) && (cfg.tall || !diff[3]);
    rec.pattern_address = {tile9[8] | (!cfg.tall & cfg.page), tile9[7:0], 1'b0, row_sel[2:0]};
    rec.x       = row.x;
    rec.palette = row.attr[1:0];
    rec.behind  = row.attr[5];
    rec.hflip   = row.attr[6];
  end

endmodule

FILE: hw/rtl/sprite_scanline_evaluator.sv
`timescale 1ns / 1ps
// Sprite scanline evaluator. A word with in_operation low writes one byte of the
// 256-byte sprite memory and keeps busy high for one cycle. A word with in_operation
// high evaluates in_line_number: the sprite memory is read one sprite per cycle, and
// the walk stops early when the per-line limit is reached; when the line is not
// visible or sprites are off, only the summary word comes out. Each found sprite comes
// out as one record word on out_strobe, and a summary word with out_last set closes
// every evaluation; the receiver cannot stall, so every word must be taken in the cycle
// it is shown. After reset the block clears all 64 rows of the sprite memory with busy
// high. Configuration writes on cfg_we take effect at once and belong to idle periods.
module sprite_scanline_evaluator #(
  parameter int SPRITE_COUNT  = sse_pkg::SPRITE_COUNT_DEF,
  parameter int MAX_PER_LINE  = sse_pkg::MAX_PER_LINE_DEF,
  parameter int VISIBLE_LINES = sse_pkg::VISIBLE_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [7:0]  in_oam_address,
  input  logic [7:0]  in_oam_data,
  input  logic [8:0]  in_line_number,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  output logic        out_strobe,
  output logic        out_is_summary,
  output logic [12:0] out_pattern_address,
  output logic [7:0]  out_sprite_x,
  output logic [1:0]  out_palette_select,
  output logic        out_behind_background,
  output logic        out_flip_horizontal,
  output logic        out_is_sprite_zero,
  output logic [3:0]  out_found_count,
  output logic        out_overflow,
  output logic        out_last
);
  import sse_pkg::*;

  localparam int CNT_W = $clog2(MAX_PER_LINE + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MERGE,
    ST_EVAL,
    ST_SUMMARY
  } state_t;

  state_t           state_r;
  sse_cfg_t         cfg_r;
  logic [ROW_W-1:0] cur_idx_r;
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic [8:0]       line_r;
  logic [ROW_W-1:0] wr_row_r;
  logic [1:0]       wr_byte_r;
  logic [7:0]       wr_data_r;

  logic             out_strobe_r;
  logic             out_is_summary_r;
  logic [12:0]      out_pattern_address_r;
  logic [7:0]       out_sprite_x_r;
  logic [1:0]       out_palette_select_r;
  logic             out_behind_background_r;
  logic             out_flip_horizontal_r;
  logic             out_is_sprite_zero_r;
  logic [3:0]       out_found_count_r;
  logic             out_overflow_r;
  logic             out_last_r;

  logic             mem_we;
  logic [ROW_W-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic [ROW_W-1:0] mem_raddr;
  logic [31:0]      mem_rdata;
  logic [31:0]      merged;
  sse_rec_t         rec;

  sse_ram #(
    .WIDTH (32),
    .DEPTH (ROWS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sse_record u_rec (
    .row  (sse_row_t'(mem_rdata)),
    .line (line_r),
    .cfg  (cfg_r),
    .rec  (rec)
  );

  // A byte write reads its sprite row at accept time and writes it back merged.
  always_comb begin
    merged = mem_rdata;
    for (int b = 0; b < 4; b++) begin
      if (wr_byte_r == 2'(b)) begin
        merged[b*8 +: 8] = wr_data_r;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_idx_r;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_raddr = (in_operation == OP_EVAL) ? '0 : in_oam_address[7:2];
      end
      ST_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_row_r;
        mem_wdata = merged;
      end
      ST_EVAL: begin
        mem_raddr = cur_idx_r + ROW_W'(1);
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cfg_r        <= '0;
      cur_idx_r    <= '0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_SPRITES_ENABLED: cfg_r.enabled <= cfg_data[0];
          REG_TALL_SPRITES:    cfg_r.tall    <= cfg_data[0];
          REG_PATTERN_PAGE:    cfg_r.page    <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        ST_CLEAR: begin
          cur_idx_r <= cur_idx_r + ROW_W'(1);
          if (cur_idx_r == ROW_W'(ROWS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            line_r    <= in_line_number;
            wr_row_r  <= in_oam_address[7:2];
            wr_byte_r <= in_oam_address[1:0];
            wr_data_r <= in_oam_data;
            count_r   <= '0;
            ovf_r     <= 1'b0;
            cur_idx_r <= '0;
            if (in_operation == OP_WRITE) begin
              state_r <= ST_MERGE;
            end else if ((in_line_number < 9'(VISIBLE_LINES)) && cfg_r.enabled) begin
              state_r <= ST_EVAL;
            end else begin
              state_r <= ST_SUMMARY;
            end
          end
        end
        ST_MERGE: begin
          state_r <= ST_IDLE;
        end
        ST_EVAL: begin
          if (rec.hit) begin
            out_strobe_r            <= 1'b1;
            out_is_summary_r        <= 1'b0;
            out_pattern_address_r   <= rec.pattern_address;
            out_sprite_x_r          <= rec.x;
            out_palette_select_r    <= rec.palette;
            out_behind_background_r <= rec.behind;
            out_flip_horizontal_r   <= rec.hflip;
            out_is_sprite_zero_r    <= (cur_idx_r == '0);
            out_found_count_r       <= '0;
            out_overflow_r          <= 1'b0;
            out_last_r              <= 1'b0;
            count_r                 <= count_r + CNT_W'(1);
          end
          // The walk ends as soon as the per-line limit is reached.
          if (rec.hit && ((count_r + CNT_W'(1)) == CNT_W'(MAX_PER_LINE))) begin
            ovf_r   <= 1'b1;
            state_r <= ST_SUMMARY;
          end else if (cur_idx_r == ROW_W'(SPRITE_COUNT - 1)) begin
            state_r <= ST_SUMMARY;
          end else begin
            cur_idx_r <= cur_idx_r + ROW_W'(1);
          end
        end
        ST_SUMMARY: begin
          out_strobe_r            <= 1'b1;
          out_is_summary_r        <= 1'b1;
          out_pattern_address_r   <= '0;
          out_sprite_x_r          <= '0;
          out_palette_select_r    <= '0;
          out_behind_background_r <= 1'b0;
          out_flip_horizontal_r   <= 1'b0;
          out_is_sprite_zero_r    <= 1'b0;
          out_found_count_r       <= 4'(count_r);
          out_overflow_r          <= ovf_r;
          out_last_r              <= 1'b1;
          state_r                 <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy                  = (state_r != ST_IDLE);
  assign out_strobe            = out_strobe_r;
  assign out_is_summary        = out_is_summary_r;
  assign out_pattern_address   = out_pattern_address_r;
  assign out_sprite_x          = out_sprite_x_r;
  assign out_palette_select    = out_palette_select_r;
  assign out_behind_background = out_behind_background_r;
  assign out_flip_horizontal   = out_flip_horizontal_r;
  assign out_is_sprite_zero    = out_is_sprite_zero_r;
  assign out_found_count       = out_found_count_r;
  assign out_overflow          = out_overflow_r;
  assign out_last              = out_last_r;

endmodule

FILE: hw/rtl/sse_checker.sv
`timescale 1ns / 1ps
`include "sprite_scanline_evaluator_assert.svh"
module sse_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_operation,
  input logic out_strobe,
  input logic out_is_summary,
  input logic out_last
);
  import sse_pkg::*;

  // An accepted evaluation makes the block busy.
  `SSE_ASSERT_NEXT(a_eval_busy, clk, rst_n, start && !busy && (in_operation == OP_EVAL), busy)
  // A byte write produces no word.
  `SSE_ASSERT_NEXT(a_write_quiet, clk, rst_n, start && !busy && (in_operation == OP_WRITE), !out_strobe)
  // Sprite records only appear while the evaluation is still running.
  `SSE_ASSERT_SAME(a_rec_busy, clk, rst_n, out_strobe && !out_is_summary, busy)
  // The block is ready again when the closing summary is shown.
  `SSE_ASSERT_SAME(a_last_idle, clk, rst_n, out_strobe && out_last, !busy)

endmodule

bind sprite_scanline_evaluator sse_checker u_sse_checker (.*);

FILE: bench/sprite_scanline_checker.sv
`timescale 1ns / 1ps
module sprite_scanline_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [7:0]  in_oam_address,
  input  logic [7:0]  in_oam_data,
  input  logic [8:0]  in_line_number,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  input  logic        out_strobe,
  input  logic        out_is_summary,
  input  logic [12:0] out_pattern_address,
  input  logic [7:0]  out_sprite_x,
  input  logic [1:0]  out_palette_select,
  input  logic        out_behind_background,
  input  logic        out_flip_horizontal,
  input  logic        out_is_sprite_zero,
  input  logic [3:0]  out_found_count,
  input  logic        out_overflow,
  input  logic        out_last,
  output int          mismatches,
  output int          words_due
);
  import sse_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic        is_summary;
    logic [12:0] pattern_address;
    logic [7:0]  sprite_x;
    logic [1:0]  palette_select;
    logic        behind_background;
    logic        flip_horizontal;
    logic        is_sprite_zero;
    logic [3:0]  found_count;
    logic        overflow;
    logic        last;
  } sprite_word_t;

  logic [7:0]   oam_shadow [256];
  logic         sprites_on;
  logic         tall_mode;
  logic         high_page;
  sprite_word_t expected_words [$];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
    end
  endtask

  // Walks the shadow memory the way the block does and queues the records for every
  // sprite on the line up to the per-line limit, then the closing summary word.
  task automatic predict_scanline(input int line);
    int           height;
    int           count;
    int           i;
    int           y;
    int           tile;
    int           row;
    int           addr;
    logic [7:0]   attr;
    logic         full;
    sprite_word_t w;
    height = tall_mode ? 16 : 8;
    count  = 0;
    full   = 1'b0;
    if (line < VISIBLE_LINES_DEF && sprites_on) begin
      for (i = 0; i < SPRITE_COUNT_DEF && !full; i++) begin
        y = int'(oam_shadow[4 * i]);
        if (line >= y && line - y < height) begin
          tile = int'(oam_shadow[4 * i + 1]);
          attr = oam_shadow[4 * i + 2];
          row  = line - y;
          // In tall mode the odd tile bit picks the upper pattern bank.
          if (height == 16 && tile % 2 == 1) begin
            tile = (tile & 'hFE) | 'h100;
          end
          if (attr[7]) begin
            row = height - 1 - row;
          end
          if (row >= 8) begin
            tile = tile + 1;
            row  = row - 8;
          end
          addr = tile * 16 + row;
          if (height == 8 && high_page) begin
            addr = addr + 'h1000;
          end
          w = '0;
          w.pattern_address   = addr[12:0];
          w.sprite_x          = oam_shadow[4 * i + 3];
          w.palette_select    = attr[1:0];
          w.behind_background = attr[5];
          w.flip_horizontal   = attr[6];
          w.is_sprite_zero    = (i == 0);
          expected_words.push_back(w);
          count++;
          full = (count == MAX_PER_LINE_DEF);
        end
      end
    end
    w = '0;
    w.is_summary  = 1'b1;
    w.found_count = count[3:0];
    w.overflow    = full;
    w.last        = 1'b1;
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    sprite_word_t got;
    sprite_word_t want;
    int           a;
    if (!rst_n) begin
      for (a = 0; a < 256; a++) begin
        oam_shadow[a] = 8'h00;
      end
      sprites_on = 1'b0;
      tall_mode  = 1'b0;
      high_page  = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPRITES_ENABLED: sprites_on = cfg_data[0];
          REG_TALL_SPRITES:    tall_mode  = cfg_data[0];
          REG_PATTERN_PAGE:    high_page  = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_operation == OP_WRITE) begin
          oam_shadow[in_oam_address] = in_oam_data;
        end else begin
          predict_scanline(int'(in_line_number));
        end
      end
      if (out_strobe) begin
        got.is_summary        = out_is_summary;
        got.pattern_address   = out_pattern_address;
        got.sprite_x          = out_sprite_x;
        got.palette_select    = out_palette_select;
        got.behind_background = out_behind_background;
        got.flip_horizontal   = out_flip_horizontal;
        got.is_sprite_zero    = out_is_sprite_zero;
        got.found_count       = out_found_count;
        got.overflow          = out_overflow;
        got.last              = out_last;
        if (expected_words.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_words.pop_front();
          check_field("is_summary", 16'(got.is_summary), 16'(want.is_summary));
          check_field("pattern_address", 16'(got.pattern_address),
                      16'(want.pattern_address));
          check_field("sprite_x", 16'(got.sprite_x), 16'(want.sprite_x));
          check_field("palette_select", 16'(got.palette_select),
                      16'(want.palette_select));
          check_field("behind_background", 16'(got.behind_background),
                      16'(want.behind_background));
          check_field("flip_horizontal", 16'(got.flip_horizontal),
                      16'(want.flip_horizontal));
          check_field("is_sprite_zero", 16'(got.is_sprite_zero),
                      16'(want.is_sprite_zero));
          check_field("found_count", 16'(got.found_count), 16'(want.found_count));
          check_field("overflow", 16'(got.overflow), 16'(want.overflow));
          check_field("last", 16'(got.last), 16'(want.last));
        end
      end
    end
    words_due = expected_words.size();
  end

endmodule

FILE: bench/tb_sprite_scanline_evaluator.sv
`timescale 1ns / 1ps
module tb_sprite_scanline_evaluator;
  import sse_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASE_WORDS = 24;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [7:0]  in_oam_address;
  logic [7:0]  in_oam_data;
  logic [8:0]  in_line_number;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [0:0]  cfg_data;
  logic        out_strobe;
  logic        out_is_summary;
  logic [12:0] out_pattern_address;
  logic [7:0]  out_sprite_x;
  logic [1:0]  out_palette_select;
  logic        out_behind_background;
  logic        out_flip_horizontal;
  logic        out_is_sprite_zero;
  logic [3:0]  out_found_count;
  logic        out_overflow;
  logic        out_last;

  int mismatches;
  int words_due;
  int cycle_count = 0;
  bit quiet_phase = 1'b0;

  sprite_scanline_evaluator u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_oam_address        (in_oam_address),
    .in_oam_data           (in_oam_data),
    .in_line_number        (in_line_number),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_strobe            (out_strobe),
    .out_is_summary        (out_is_summary),
    .out_pattern_address   (out_pattern_address),
    .out_sprite_x          (out_sprite_x),
    .out_palette_select    (out_palette_select),
    .out_behind_background (out_behind_background),
    .out_flip_horizontal   (out_flip_horizontal),
    .out_is_sprite_zero    (out_is_sprite_zero),
    .out_found_count       (out_found_count),
    .out_overflow          (out_overflow),
    .out_last              (out_last)
  );

  sprite_scanline_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_operation          (in_operation),
    .in_oam_address        (in_oam_address),
    .in_oam_data           (in_oam_data),
    .in_line_number        (in_line_number),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_strobe            (out_strobe),
    .out_is_summary        (out_is_summary),
    .out_pattern_address   (out_pattern_address),
    .out_sprite_x          (out_sprite_x),
    .out_palette_select    (out_palette_select),
    .out_behind_background (out_behind_background),
    .out_flip_horizontal   (out_flip_horizontal),
    .out_is_sprite_zero    (out_is_sprite_zero),
    .out_found_count       (out_found_count),
    .out_overflow          (out_overflow),
    .out_last              (out_last),
    .mismatches            (mismatches),
    .words_due             (words_due)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long hold-off.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 9);
    if (quiet_phase || roll < 5) begin
      return 0;
    end else if (roll < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic op, input logic [7:0] addr,
                           input logic [7:0] data, input logic [8:0] line);
    int n;
    n = gap_length();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_oam_address <= addr;
    in_oam_data    <= data;
    in_line_number <= line;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_byte(input logic [7:0] addr, input logic [7:0] data);
    send_word(OP_WRITE, addr, data, 9'($urandom_range(0, 311)));
  endtask

  task automatic scan_line(input int line);
    send_word(OP_EVAL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 9'(line));
  endtask

  task automatic place_sprite(input int idx, input logic [7:0] y, input logic [7:0] tile,
                              input logic [7:0] attr, input logic [7:0] x);
    write_byte(8'(4 * idx), y);
    write_byte(8'(4 * idx + 1), tile);
    write_byte(8'(4 * idx + 2), attr);
    write_byte(8'(4 * idx + 3), x);
  endtask

  // Holds off until every expected word is in and the block has gone quiet,
  // with a margin after it for a trailing sprite memory write.
  task automatic settle();
    start <= 1'b0;
    while (words_due != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic en, input logic tall, input logic page,
                            input logic poke_unused);
    settle();
    if (poke_unused) begin
      write_reg(REG_UNUSED, 1'b1);
    end
    write_reg(REG_SPRITES_ENABLED, en);
    write_reg(REG_TALL_SPRITES, tall);
    write_reg(REG_PATTERN_PAGE, page);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int p;
    int sent;
    int roll;
    int line;
    int n;
    int height;
    int y;
    int idx;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_WRITE;
    in_oam_address = 8'h00;
    in_oam_data    = 8'h00;
    in_line_number = 9'd0;
    cfg_we         = 1'b0;
    cfg_index      = REG_SPRITES_ENABLED;
    cfg_data       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed words. With sprites off after reset only a summary comes back.
    scan_line(0);
    set_config(1'b1, 1'b0, 1'b0, 1'b1);
    // Cleared memory puts every sprite on line 0, so the per-line limit trips.
    scan_line(0);
    place_sprite(0, 8'd5, 8'hFF, 8'hE3, 8'hFF);
    scan_line(5);
    scan_line(240);
    scan_line(311);
    set_config(1'b1, 1'b1, 1'b0, 1'b0);
    scan_line(12);
    scan_line(20);
    place_sprite(63, 8'hEF, 8'h01, 8'h00, 8'h00);
    scan_line(239);
    set_config(1'b1, 1'b0, 1'b1, 1'b0);
    scan_line(239);
    scan_line(0);
    write_byte(8'h00, 8'hFF);
    scan_line(255);
    set_config(1'b0, 1'b1, 1'b1, 1'b0);
    scan_line(100);

    // Random phases over every register setting, one of them with sprites off.
    for (p = 0; p < 8; p++) begin
      set_config(p != 5, p[0], p[1], 1'b0);
      quiet_phase = (p == 2 || p == 6);
      height = p[0] ? 16 : 8;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          // Crowd sprites around one line, then scan it and its neighbors.
          line = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 308)
                                             : $urandom_range(0, 239);
          n = $urandom_range(1, 10);
          repeat (n) begin
            idx = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 63);
            y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                            : line - $urandom_range(0, height - 1);
            place_sprite(idx, y[7:0], 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end
          sent += 4 * n;
          repeat ($urandom_range(1, 3)) begin
            scan_line(line + $urandom_range(0, 3));
            sent++;
          end
        end else if (roll < 80) begin
          write_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          sent++;
        end else if (roll < 97) begin
          scan_line($urandom_range(0, 311));
          sent++;
        end else begin
          settle();
        end
      end
    end

    settle();
    repeat (70) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
